// ===== rtl/newreno_congestion_window_macros.svh =====
// Assertion macros shared by the congestion window RTL.
`ifndef NEWRENO_CONGESTION_WINDOW_MACROS_SVH
`define NEWRENO_CONGESTION_WINDOW_MACROS_SVH
`ifndef SYNTHESIS
`define NRCW_ASSERT_NOW(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("nrcw: same-cycle check failed");
`define NRCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nrcw: next-cycle check failed");
`else
`define NRCW_ASSERT_NOW(label, clk, rst, cond)
`define NRCW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/nrcw_pkg.sv =====
package nrcw_pkg;

  localparam int WIN_W        = 32;
  localparam int MDS_W        = 16;
  localparam int TIME_FIELD_W = 48;
  localparam int PROD_W       = MDS_W + WIN_W;

  localparam logic [WIN_W-1:0] WIN_MAX          = '1;
  localparam logic [MDS_W-1:0] MDS_RESET        = 16'd1200;
  localparam logic [WIN_W-1:0] INIT_WIN_RESET   = 32'd12000;
  localparam logic [WIN_W-1:0] MIN_WIN_RESET    = 32'd2400;

  typedef enum logic [1:0] {
    CMD_ACK       = 2'd0,
    CMD_LOSS      = 2'd1,
    CMD_WIN_RESET = 2'd2,
    CMD_REINIT    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MAX_DATAGRAM = 2'd0,
    REG_INIT_WINDOW  = 2'd1,
    REG_MIN_WINDOW   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/nrcw_divider.sv =====
module nrcw_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nrcw_pkg::PROD_W-1:0]   dividend,
  input  logic [nrcw_pkg::WIN_W-1:0]    divisor,
  output logic [nrcw_pkg::PROD_W-1:0]   quotient,
  output nrcw_pkg::div_status_t         status
);

  localparam int CNT_W = $clog2(nrcw_pkg::PROD_W + 1);

  logic [nrcw_pkg::WIN_W-1:0]  rem;
  logic [nrcw_pkg::WIN_W:0]    rem_sh;
  logic [nrcw_pkg::WIN_W:0]    rem_next;
  logic                        fits;
  logic [nrcw_pkg::PROD_W-1:0] quo;
  logic [nrcw_pkg::WIN_W-1:0]  dvsr;
  logic [CNT_W-1:0]            cnt;
  logic                        busy;
  logic                        done;

  // One restoring step: bring in the next dividend bit and try the subtract.
  always_comb begin
    rem_sh   = {rem, quo[nrcw_pkg::PROD_W-1]};
    fits     = rem_sh >= {1'b0, dvsr};
    rem_next = fits ? (rem_sh - {1'b0, dvsr}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
      cnt  <= CNT_W'(nrcw_pkg::PROD_W);
    end else if (busy) begin
      rem  <= rem_next[nrcw_pkg::WIN_W-1:0];
      quo  <= {quo[nrcw_pkg::PROD_W-2:0], fits};
      cnt  <= cnt - CNT_W'(1);
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== rtl/newreno_congestion_window.sv =====
// NewReno congestion window for one connection.
// Events enter on the s_axis channel: tuser carries the command (ack, loss,
// window reset, reinitialise) and tdata the send stamp, current time and
// acked byte count. Every event yields exactly one result on m_axis with the
// window, the slow-start threshold, the slow-start flag and the start time of
// the current recovery epoch.
// The cfg channel writes the datagram size, initial window and minimum
// window; it is always ready and is meant to be used between events.
// An event passes from transfer through S_EXEC and S_WB to the output
// register, except an ack in congestion avoidance, which runs a bit-serial
// 48-by-32 divider (one quotient bit a cycle) in S_DSTART and S_DIV before
// S_WB. One event is in flight at a time; s_axis_tready is high only while
// the sequencer is idle, so no event is taken before the last has left S_WB.
// The result sits in an output register, so the next event may be taken while
// it waits. If the receiver stalls, the sequencer holds the following result
// until the register is free.
// Synchronous reset restores the registers to their defaults, reloads the
// window with the default initial window and drops the output valid.
module newreno_congestion_window #(
  parameter int TIME_BITS = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [47:0] send_stamp, [95:48] now, [127:96] acked_bytes
  input  logic [127:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] window, [63:32] threshold, [64] slow_start,
  // [112:65] recovery_began, [119:113] zero
  output logic [119:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int TW = (TIME_BITS < nrcw_pkg::TIME_FIELD_W) ?
                      TIME_BITS : nrcw_pkg::TIME_FIELD_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_DSTART = 5'b00100,
    S_DIV    = 5'b01000,
    S_WB     = 5'b10000
  } state_t;

  state_t state;

  logic [nrcw_pkg::MDS_W-1:0]  max_datagram;
  logic [nrcw_pkg::WIN_W-1:0]  init_window;
  logic [nrcw_pkg::WIN_W-1:0]  min_window;

  logic [nrcw_pkg::WIN_W-1:0]  cwnd;
  logic [nrcw_pkg::WIN_W-1:0]  ssthresh;
  logic [TW-1:0]               rec_start;

  nrcw_pkg::cmd_t              ev_cmd;
  logic [TW-1:0]               ev_sent;
  logic [TW-1:0]               ev_now;
  logic [nrcw_pkg::WIN_W-1:0]  ev_acked;

  logic [nrcw_pkg::PROD_W-1:0] prod;
  logic [nrcw_pkg::PROD_W-1:0] quotient;
  nrcw_pkg::div_status_t       div_st;

  logic                        in_recovery;
  logic [nrcw_pkg::WIN_W:0]    ss_sum;
  logic [nrcw_pkg::PROD_W:0]   ca_sum;
  logic [nrcw_pkg::WIN_W-1:0]  half;
  logic [nrcw_pkg::WIN_W-1:0]  loss_win;
  logic                        out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    in_recovery = ev_sent <= rec_start;
    ss_sum      = {1'b0, cwnd} + {1'b0, ev_acked};
    ca_sum      = (nrcw_pkg::PROD_W + 1)'(cwnd) + {1'b0, quotient};
    half        = cwnd >> 1;
    loss_win    = (half > min_window) ? half : min_window;
  end

  nrcw_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DSTART),
    .dividend (prod),
    .divisor  (cwnd),
    .quotient (quotient),
    .status   (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_datagram <= nrcw_pkg::MDS_RESET;
      init_window  <= nrcw_pkg::INIT_WIN_RESET;
      min_window   <= nrcw_pkg::MIN_WIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        nrcw_pkg::REG_MAX_DATAGRAM: max_datagram <= cfg_data[nrcw_pkg::MDS_W-1:0];
        nrcw_pkg::REG_INIT_WINDOW:  init_window  <= cfg_data;
        nrcw_pkg::REG_MIN_WINDOW:   min_window   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ev_cmd   <= nrcw_pkg::cmd_t'(s_axis_tuser);
      ev_sent  <= s_axis_tdata[TW-1:0];
      ev_now   <= s_axis_tdata[nrcw_pkg::TIME_FIELD_W +: TW];
      ev_acked <= s_axis_tdata[127:96];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cwnd          <= nrcw_pkg::INIT_WIN_RESET;
      ssthresh      <= nrcw_pkg::WIN_MAX;
      rec_start     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_WB && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (ev_cmd)
            nrcw_pkg::CMD_ACK: begin
              if (!in_recovery && cwnd >= ssthresh && cwnd != '0) begin
                prod  <= nrcw_pkg::PROD_W'(max_datagram) * nrcw_pkg::PROD_W'(ev_acked);
                state <= S_DSTART;
              end else begin
                state <= S_WB;
                if (!in_recovery && cwnd < ssthresh) begin
                  cwnd <= ss_sum[nrcw_pkg::WIN_W] ? nrcw_pkg::WIN_MAX :
                          ss_sum[nrcw_pkg::WIN_W-1:0];
                end
              end
            end
            nrcw_pkg::CMD_LOSS: begin
              state <= S_WB;
              if (!in_recovery) begin
                rec_start <= ev_now;
                cwnd      <= loss_win;
                ssthresh  <= loss_win;
              end
            end
            nrcw_pkg::CMD_WIN_RESET: begin
              state <= S_WB;
              cwnd  <= min_window;
            end
            nrcw_pkg::CMD_REINIT: begin
              state     <= S_WB;
              cwnd      <= init_window;
              ssthresh  <= nrcw_pkg::WIN_MAX;
              rec_start <= '0;
            end
            default: state <= S_WB;
          endcase
        end
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (div_st.done) begin
            // Growth saturates at the largest window.
            cwnd  <= (|ca_sum[nrcw_pkg::PROD_W:nrcw_pkg::WIN_W]) ? nrcw_pkg::WIN_MAX :
                     ca_sum[nrcw_pkg::WIN_W-1:0];
            state <= S_WB;
          end
        end
        S_WB: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WB && out_free) begin
      m_axis_tdata <= {7'd0, nrcw_pkg::TIME_FIELD_W'(rec_start), cwnd < ssthresh,
                       ssthresh, cwnd};
    end
  end

  `include "newreno_congestion_window_macros.svh"

  `NRCW_ASSERT_NOW(a_done_in_div, clk, rst, !div_st.done || state == S_DIV)
  `NRCW_ASSERT_NOW(a_div_idle_at_start, clk, rst, state != S_DSTART || !div_st.busy)
  `NRCW_ASSERT_NEXT(a_div_to_wb, clk, rst, state == S_DIV && div_st.done, state == S_WB)
  `NRCW_ASSERT_NEXT(a_wb_shows, clk, rst, state == S_WB && out_free, m_axis_tvalid)
  `NRCW_ASSERT_NOW(a_flag_matches, clk, rst,
                   !m_axis_tvalid || m_axis_tdata[64] == (m_axis_tdata[31:0] < m_axis_tdata[63:32]))

endmodule
